// ===== design/scov_pkg.sv =====
package scov_pkg;

    localparam int VAL_W    = 16;
    localparam int DIM_W    = 4;
    localparam int COV_W    = 40;
    localparam int ENTRY_W  = 3;
    localparam int DIM_LIMIT = 8;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_LOAD      = 10'b00_0000_0010,
        ST_PROD      = 10'b00_0000_0100,
        ST_DRAIN     = 10'b00_0000_1000,
        ST_OUT_RD    = 10'b00_0001_0000,
        ST_OUT_MUL   = 10'b00_0010_0000,
        ST_OUT_SUB   = 10'b00_0100_0000,
        ST_OUT_START = 10'b00_1000_0000,
        ST_OUT_DIV   = 10'b01_0000_0000,
        ST_OUT_PUSH  = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== design/scov_ram.sv =====
module scov_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/scov_div.sv =====
module scov_div #(
    parameter int DVD_W = 69,
    parameter int DVS_W = 26
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DVD_W-1:0]          dividend,
    input  logic [DVS_W-1:0]          divisor,
    output scov_pkg::div_status_t     status,
    output logic [DVD_W-1:0]          quotient
);
    import scov_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] diff;
    logic             ge;

    // restoring long division, one quotient bit per cycle
    assign rem_sh = {rem_reg, q_reg[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = ~diff[DVS_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;
endmodule

// ===== design/sample_covariance_engine_core.sv =====
// Population covariance engine.
// s_ channel: one sample word per handshake, row-major, dimensions words per
// row; s_end_of_set on the last word of a set starts the matrix readout.
// cfg channel: writes the dimensions register (0 acts as 1, capped at 8) and
// clears the set in progress. Accepted only while the block is idle.
// m_ channel: D*D covariance words in row-major order, 8 fraction bits,
// m_last_entry on the final one, empty/dropped flags on every word.
// A sample word that does not close a row is only stored in the row buffer. A
// word that closes a row below the MAX_ROWS limit runs the product-sum memory
// pass, which walks every D*D product through the memory's read and write
// ports. Each matrix word then passes through the bit-serial divider, which
// is skipped when the set is empty. No input is taken during a pass or the
// readout.
// The result register parts the sides: a stalled receiver holds the current
// word, and the block waits only when the next word is ready to load.
// Reset: dimensions = 2, set empty. Product sums carry valid bits, so reset
// and set clearing need no memory sweep.
module sample_covariance_engine_core #(
    parameter int MAX_DIMS      = 8,
    parameter int MAX_ROWS      = 4096,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [scov_pkg::VAL_W-1:0]     s_sample_value,
    input  logic                                  s_end_of_set,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [scov_pkg::COV_W-1:0]     m_cov_value,
    output logic [scov_pkg::ENTRY_W-1:0]          m_entry_row,
    output logic [scov_pkg::ENTRY_W-1:0]          m_entry_col,
    output logic                                  m_last_entry,
    output logic                                  m_empty_set,
    output logic                                  m_rows_dropped,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [scov_pkg::DIM_W-1:0]            cfg_dimensions
);
    import scov_pkg::*;

    localparam int CAP    = MAX_DIMS < DIM_LIMIT ? MAX_DIMS : DIM_LIMIT;
    localparam int IDX_W  = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
    localparam int PDEPTH = MAX_DIMS * MAX_DIMS;
    localparam int PA_W   = PDEPTH > 1 ? $clog2(PDEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int SUM_W  = VAL_W + CNT_W;
    localparam int PROD_W = 2 * VAL_W;
    localparam int PS_W   = 2 * VAL_W + CNT_W;
    localparam int M1_W   = CNT_W + 1 + PS_W;
    localparam int M2_W   = 2 * SUM_W;
    localparam int NUM_W  = (M1_W > M2_W ? M1_W : M2_W) + 1;
    localparam int DEN_W  = 2 * CNT_W;
    localparam int DVD_W  = NUM_W + FRACTION_BITS;
    localparam int SAT_W  = DVD_W + COV_W;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]        dims_reg;
    logic [IDX_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;
    logic                    eos_reg;
    logic [IDX_W-1:0]        i_reg, j_reg;
    logic signed [VAL_W-1:0] rb_reg [MAX_DIMS];
    logic signed [SUM_W-1:0] dsum_reg [MAX_DIMS];
    logic [PDEPTH-1:0]       pvalid_reg;

    logic signed [VAL_W-1:0]  a_reg, a1_reg, b1_reg;
    logic                     v1_reg, v2_reg;
    logic [PA_W-1:0]          addr1_reg, addr2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PS_W-1:0]   rd_reg;

    logic signed [SUM_W-1:0] sa_reg;
    logic signed [M1_W-1:0]  m1_reg;
    logic signed [M2_W-1:0]  m2_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [COV_W-1:0]        res_reg;

    logic                    m_valid_reg;

    logic [DIM_W-1:0]        dact;
    logic [IDX_W-1:0]        dl;
    logic                    s_acc, cfg_acc, out_free, clear_set;
    logic [PA_W-1:0]         cur_addr;
    logic [PS_W-1:0]         ram_rdata;
    logic signed [PS_W-1:0]  sab;
    logic signed [M1_W-1:0]  m1_next;
    logic signed [M2_W-1:0]  m2_next;
    logic [NUM_W-1:0]        mag;
    logic                    div_start;
    div_status_t             div_st;
    logic [DVD_W-1:0]        quot;
    logic [SAT_W-1:0]        qext, lim, qsat;
    logic [COV_W-1:0]        res_next;
    logic                    last_pair;

    always_comb begin
        if (dims_reg == '0) begin
            dact = DIM_W'(1);
        end else if (dims_reg > DIM_W'(CAP)) begin
            dact = DIM_W'(CAP);
        end else begin
            dact = dims_reg;
        end
    end
    assign dl = IDX_W'(dact - 1'b1);

    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_pair = (i_reg == dl) && (j_reg == dl);
    assign cur_addr  = PA_W'(int'(i_reg) * MAX_DIMS + int'(j_reg));

    scov_ram #(
        .WIDTH(PS_W),
        .DEPTH(PDEPTH)
    ) u_psum (
        .aclk (aclk),
        .we   (v2_reg),
        .waddr(addr2_reg),
        .wdata(PS_W'(rd_reg + PS_W'(prod_reg))),
        .raddr(cur_addr),
        .rdata(ram_rdata)
    );

    // entries not yet written in this set read as zero
    assign sab     = pvalid_reg[addr1_reg] ? $signed(ram_rdata) : '0;
    assign m1_next = $signed({1'b0, cnt_reg}) * sab;
    assign m2_next = sa_reg * dsum_reg[j_reg];

    assign mag       = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign div_start = (state_reg == ST_OUT_START);

    scov_div #(
        .DVD_W(DVD_W),
        .DVS_W(DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(DVD_W'(mag) << FRACTION_BITS),
        .divisor (den_reg),
        .status  (div_st),
        .quotient(quot)
    );

    // clamp to the signed output range, magnitude first
    assign qext = SAT_W'(quot);
    assign lim  = num_reg[NUM_W-1] ? (SAT_W'(1) << (COV_W - 1))
                                   : ((SAT_W'(1) << (COV_W - 1)) - 1'b1);
    assign qsat = (qext > lim) ? lim : qext;
    assign res_next = num_reg[NUM_W-1] ? COV_W'(-qsat) : COV_W'(qsat);

    assign clear_set = cfg_acc || ((state_reg == ST_OUT_PUSH) && out_free && last_pair);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (pos_reg == dl && cnt_reg < CNT_W'(MAX_ROWS)) begin
                        state_next = ST_LOAD;
                    end else if (s_end_of_set) begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_LOAD:  state_next = ST_PROD;
            ST_PROD: begin
                if (j_reg == dl) begin
                    state_next = (i_reg == dl) ? ST_DRAIN : ST_LOAD;
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = eos_reg ? ST_OUT_RD : ST_IDLE;
                end
            end
            ST_OUT_RD:  state_next = ST_OUT_MUL;
            ST_OUT_MUL: state_next = ST_OUT_SUB;
            ST_OUT_SUB: state_next = (cnt_reg == '0) ? ST_OUT_PUSH : ST_OUT_START;
            ST_OUT_START: state_next = ST_OUT_DIV;
            ST_OUT_DIV: begin
                if (div_st.done) begin
                    state_next = ST_OUT_PUSH;
                end
            end
            ST_OUT_PUSH: begin
                if (out_free) begin
                    state_next = last_pair ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dims_reg    <= DIM_RESET;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            eos_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            pvalid_reg  <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_DIMS; k++) begin
                dsum_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_PROD);
            v2_reg    <= v1_reg;
            if (v2_reg) begin
                pvalid_reg[addr2_reg] <= 1'b1;
            end
            m_valid_reg <= ((state_reg == ST_OUT_PUSH) && out_free) ||
                           (m_valid_reg && !m_ready);

            case (state_reg)
                ST_IDLE: begin
                    if (cfg_acc) begin
                        dims_reg <= cfg_dimensions;
                    end else if (s_acc) begin
                        eos_reg <= s_end_of_set;
                        i_reg   <= '0;
                        j_reg   <= '0;
                        if (pos_reg == dl) begin
                            pos_reg <= '0;
                            if (cnt_reg >= CNT_W'(MAX_ROWS)) begin
                                ovf_reg <= 1'b1;
                            end else begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end else begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                ST_LOAD: begin
                    dsum_reg[i_reg] <= dsum_reg[i_reg] + SUM_W'(rb_reg[i_reg]);
                    j_reg <= '0;
                end
                ST_PROD: begin
                    if (j_reg == dl) begin
                        j_reg <= '0;
                        if (i_reg == dl) begin
                            i_reg <= '0;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_OUT_PUSH: begin
                    if (out_free) begin
                        if (j_reg == dl) begin
                            j_reg <= '0;
                            i_reg <= i_reg + 1'b1;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            if (clear_set) begin
                pos_reg    <= '0;
                cnt_reg    <= '0;
                ovf_reg    <= 1'b0;
                pvalid_reg <= '0;
                for (int k = 0; k < MAX_DIMS; k++) begin
                    dsum_reg[k] <= '0;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rb_reg[pos_reg] <= s_sample_value;
        end
        if (state_reg == ST_LOAD) begin
            a_reg <= rb_reg[i_reg];
        end
        a1_reg    <= a_reg;
        b1_reg    <= rb_reg[j_reg];
        addr1_reg <= cur_addr;
        prod_reg  <= a1_reg * b1_reg;
        rd_reg    <= sab;
        addr2_reg <= addr1_reg;
        if (state_reg == ST_OUT_RD) begin
            sa_reg  <= dsum_reg[i_reg];
            den_reg <= DEN_W'(cnt_reg) * DEN_W'(cnt_reg);
        end
        if (state_reg == ST_OUT_MUL) begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
        if (state_reg == ST_OUT_SUB) begin
            num_reg <= NUM_W'(m1_reg) - NUM_W'(m2_reg);
            res_reg <= '0;
        end
        if (state_reg == ST_OUT_DIV && div_st.done) begin
            res_reg <= res_next;
        end
        if (state_reg == ST_OUT_PUSH && out_free) begin
            m_cov_value    <= $signed(res_reg);
            m_entry_row    <= ENTRY_W'(i_reg);
            m_entry_col    <= ENTRY_W'(j_reg);
            m_last_entry   <= last_pair;
            m_empty_set    <= (cnt_reg == '0);
            m_rows_dropped <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ROWS))
        else $error("row count beyond limit");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= dl)
        else $error("column position beyond row length");

    a_wb_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (state_reg == ST_LOAD || state_reg == ST_PROD || state_reg == ST_DRAIN))
        else $error("product sum write outside accumulate pass");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> state_reg == ST_OUT_DIV)
        else $error("divider finished outside readout");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(m_cov_value) && $stable(m_last_entry)))
        else $error("result word changed while stalled");
`endif
endmodule
